/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the sieve prime counter top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPC_CHK_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("spc assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPC_CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spc assertion failed");

// Delayed form: the consequent must hold after the antecedent, not in its cycle.
`define SPC_CHK_TWO(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error("spc assertion failed");

`endif

/* rtl/spc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg
// Widths, control word layout and microprogram of the sieve prime counter.
// ----------------------------------------------------------------------------
package spc_pkg;

  // Field and register widths
  localparam int unsigned LIM_W  = 16;          // limit field
  localparam int unsigned CNT_W  = 13;          // prime_count field
  localparam int unsigned K_W    = LIM_W + 1;   // index, may pass the limit
  localparam int unsigned P_W    = LIM_W / 2 + 1; // base prime, up to one past sqrt
  localparam int unsigned STEP_W = 4;
  localparam int unsigned DEPTH  = 2 ** LIM_W;  // sieve store entries

  localparam int unsigned FIRST_PRIME = 2;

  typedef logic [STEP_W-1:0] step_t;

  // Microprogram step addresses
  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_CHK    = 4'd1;
  localparam step_t STEP_INIT   = 4'd2;
  localparam step_t STEP_PSET   = 4'd3;
  localparam step_t STEP_PTEST  = 4'd4;
  localparam step_t STEP_PCHK   = 4'd5;
  localparam step_t STEP_MARK   = 4'd6;
  localparam step_t STEP_PNEXT  = 4'd7;
  localparam step_t STEP_CSET   = 4'd8;
  localparam step_t STEP_CRUN   = 4'd9;
  localparam step_t STEP_CLAST  = 4'd10;
  localparam step_t STEP_OUT    = 4'd11;
  localparam step_t STEP_RETURN = 4'd12;

  typedef enum logic [2:0] {
    K_HOLD, K_ZERO, K_INC, K_LOAD_SQ, K_ADD_P, K_TWO
  } k_op_t;

  typedef enum logic [1:0] {
    P_HOLD, P_INIT, P_INC
  } p_op_t;

  typedef enum logic [1:0] {
    T_HOLD, T_CLEAR, T_ACC
  } tot_op_t;

  typedef enum logic [1:0] {
    F_HOLD, F_SET, F_CLR
  } pend_op_t;

  // Jump conditions: jump to target when true, otherwise fall through
  typedef enum logic [3:0] {
    C_NEVER, C_ALWAYS, C_NO_IN, C_LIM_SMALL, C_K_NE_LIM,
    C_SQ_GT_LIM, C_BIT_CLEAR, C_KP_LE_LIM, C_NO_OUT
  } cond_t;

  // One control word
  typedef struct packed {
    logic     in_ready;   // accept a limit
    logic     out_valid;  // present the count
    logic     mem_we;     // write the store at k
    logic     wr_init;    // write value: 1 for k >= 2, else 0
    logic     rd_k;       // read address: k, else p
    k_op_t    k_op;
    p_op_t    p_op;
    tot_op_t  tot_op;
    pend_op_t pend_op;
    cond_t    cond;
    step_t    target;
  } uword_t;

  // Flags from datapath to sequencer
  typedef struct packed {
    logic lim_small;
    logic k_eq_lim;
    logic sq_gt_lim;
    logic bit_set;
    logic kp_le_lim;
  } dp_status_t;

  // Microprogram ROM
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    begin
      w = '0;
      case (step)
        STEP_IDLE: begin
          w.in_ready = 1'b1;
          w.k_op     = K_ZERO;
          w.tot_op   = T_CLEAR;
          w.cond     = C_NO_IN;
          w.target   = STEP_IDLE;
        end
        STEP_CHK: begin
          w.cond   = C_LIM_SMALL;
          w.target = STEP_OUT;
        end
        STEP_INIT: begin
          w.mem_we  = 1'b1;
          w.wr_init = 1'b1;
          w.k_op    = K_INC;
          w.cond    = C_K_NE_LIM;
          w.target  = STEP_INIT;
        end
        STEP_PSET: begin
          w.p_op = P_INIT;
        end
        STEP_PTEST: begin
          w.cond   = C_SQ_GT_LIM;
          w.target = STEP_CSET;
        end
        STEP_PCHK: begin
          w.k_op   = K_LOAD_SQ;
          w.cond   = C_BIT_CLEAR;
          w.target = STEP_PNEXT;
        end
        STEP_MARK: begin
          w.mem_we = 1'b1;
          w.k_op   = K_ADD_P;
          w.cond   = C_KP_LE_LIM;
          w.target = STEP_MARK;
        end
        STEP_PNEXT: begin
          w.p_op   = P_INC;
          w.cond   = C_ALWAYS;
          w.target = STEP_PTEST;
        end
        STEP_CSET: begin
          w.k_op    = K_TWO;
          w.tot_op  = T_CLEAR;
          w.pend_op = F_CLR;
        end
        STEP_CRUN: begin
          w.rd_k    = 1'b1;
          w.k_op    = K_INC;
          w.tot_op  = T_ACC;
          w.pend_op = F_SET;
          w.cond    = C_K_NE_LIM;
          w.target  = STEP_CRUN;
        end
        STEP_CLAST: begin
          w.tot_op  = T_ACC;
          w.pend_op = F_CLR;
        end
        STEP_OUT: begin
          w.out_valid = 1'b1;
          w.cond      = C_NO_OUT;
          w.target    = STEP_OUT;
        end
        STEP_RETURN: begin
          w.cond   = C_ALWAYS;
          w.target = STEP_IDLE;
        end
        default: begin
          w.cond   = C_ALWAYS;
          w.target = STEP_IDLE;
        end
      endcase
      return w;
    end
  endfunction

endpackage

/* rtl/spc_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_in_if
// Limit channel: valid/ready handshake carrying one limit per transaction.
// ----------------------------------------------------------------------------
interface spc_in_if;
  logic                      valid;
  logic                      ready;
  logic [spc_pkg::LIM_W-1:0] limit;

  modport source (output valid, output limit, input ready);
  modport sink   (input valid, input limit, output ready);
endinterface

/* rtl/spc_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_out_if
// Result channel: valid/ready handshake carrying one prime count.
// ----------------------------------------------------------------------------
interface spc_out_if;
  logic                      valid;
  logic                      ready;
  logic [spc_pkg::CNT_W-1:0] prime_count;

  modport source (output valid, output prime_count, input ready);
  modport sink   (input valid, input prime_count, output ready);
endinterface

/* rtl/sieve_prime_counter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sieve_prime_counter_top
// Counts the primes up to a limit with a microcoded Sieve of Eratosthenes.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                | meaning
//  ----------+-----+------------------------+-------------------------------
//  in_ch     | in  | limit [15:0]           | inclusive upper bound
//  out_ch    | out | prime_count [12:0]     | primes in 2..limit
//
// One limit at a time. A limit below 2 goes from the check step straight to the
// output step with a zero count. Otherwise the result follows the init, mark
// and count passes, paced by the single write port and single read port of the
// 64K-bit store; a return step passes before the next limit is taken.
// rst (synchronous) returns the sequencer to idle; the store is not cleared.
// A result held by out_ch.ready low stalls the sequencer in its output step.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sieve_prime_counter_top (
  input logic        clk,
  input logic        rst,
  spc_in_if.sink     in_ch,
  spc_out_if.source  out_ch
);

  spc_pkg::uword_t           uw;
  spc_pkg::dp_status_t       st;
  logic                      in_accept;
  logic                      small_accept;
  logic                      mem_we;
  logic [spc_pkg::LIM_W-1:0] waddr;
  logic                      wdata;
  logic [spc_pkg::LIM_W-1:0] raddr;
  logic                      rdata;
  logic [spc_pkg::CNT_W-1:0] prime_count;

  // Handshakes come straight from the control word
  assign in_ch.ready        = uw.in_ready;
  assign out_ch.valid       = uw.out_valid;
  assign out_ch.prime_count = prime_count;
  assign in_accept          = in_ch.valid && uw.in_ready;
  assign small_accept       = in_accept &&
                              (in_ch.limit < spc_pkg::LIM_W'(spc_pkg::FIRST_PRIME));

  spc_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .st        (st),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .uw        (uw)
  );

  spc_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .uw          (uw),
    .in_accept   (in_accept),
    .limit       (in_ch.limit),
    .rdata       (rdata),
    .st          (st),
    .mem_we      (mem_we),
    .waddr       (waddr),
    .wdata       (wdata),
    .raddr       (raddr),
    .prime_count (prime_count)
  );

  spc_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Never ready for a limit while a result is on offer
  `SPC_CHK_SAME(a_in_out_excl, clk, rst, in_ch.ready, !out_ch.valid)
  // One limit at a time
  `SPC_CHK_NEXT(a_busy_after_in, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  // A result is delivered once
  `SPC_CHK_NEXT(a_out_once, clk, rst, out_ch.valid && out_ch.ready, !out_ch.valid)
  // Small limits short-cut to a zero count
  `SPC_CHK_TWO(a_small_zero, clk, rst, small_accept, out_ch.valid && (out_ch.prime_count == '0))

endmodule

/* rtl/spc_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_store
// 64K x 1 sieve bit store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module spc_store (
  input  logic                      clk,
  input  logic                      we,
  input  logic [spc_pkg::LIM_W-1:0] waddr,
  input  logic                      wdata,
  input  logic [spc_pkg::LIM_W-1:0] raddr,
  output logic                      rdata
);

  logic mem [0:spc_pkg::DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/spc_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module spc_seq (
  input  logic                clk,
  input  logic                rst,
  input  spc_pkg::dp_status_t st,
  input  logic                in_valid,
  input  logic                out_ready,
  output spc_pkg::uword_t     uw
);

  spc_pkg::step_t pc;
  spc_pkg::step_t pc_next;
  logic           take;

  // Control word for the current step
  assign uw = spc_pkg::ucode(pc);

  // Jump condition select
  always_comb begin
    case (uw.cond)
      spc_pkg::C_NEVER:     take = 1'b0;
      spc_pkg::C_ALWAYS:    take = 1'b1;
      spc_pkg::C_NO_IN:     take = !in_valid;
      spc_pkg::C_LIM_SMALL: take = st.lim_small;
      spc_pkg::C_K_NE_LIM:  take = !st.k_eq_lim;
      spc_pkg::C_SQ_GT_LIM: take = st.sq_gt_lim;
      spc_pkg::C_BIT_CLEAR: take = !st.bit_set;
      spc_pkg::C_KP_LE_LIM: take = st.kp_le_lim;
      spc_pkg::C_NO_OUT:    take = !out_ready;
      default:              take = 1'b1;
    endcase
  end

  assign pc_next = take ? uw.target : spc_pkg::step_t'(pc + 1'b1);

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= spc_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* rtl/spc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_dp
// Sieve datapath: limit, index, base prime, its square and the prime tally.
// ----------------------------------------------------------------------------
module spc_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  spc_pkg::uword_t           uw,
  input  logic                      in_accept,
  input  logic [spc_pkg::LIM_W-1:0] limit,
  input  logic                      rdata,
  output spc_pkg::dp_status_t       st,
  output logic                      mem_we,
  output logic [spc_pkg::LIM_W-1:0] waddr,
  output logic                      wdata,
  output logic [spc_pkg::LIM_W-1:0] raddr,
  output logic [spc_pkg::CNT_W-1:0] prime_count
);

  logic [spc_pkg::LIM_W-1:0] lim;
  logic [spc_pkg::K_W-1:0]   k;
  logic [spc_pkg::K_W-1:0]   k_next;
  logic [spc_pkg::P_W-1:0]   p;
  logic [spc_pkg::K_W-1:0]   sq;
  logic [spc_pkg::CNT_W-1:0] total;
  logic                      pend;
  logic [spc_pkg::K_W-1:0]   lim_ext;
  logic [spc_pkg::K_W-1:0]   k_plus_p;

  assign lim_ext  = spc_pkg::K_W'(lim);
  assign k_plus_p = k + spc_pkg::K_W'(p);

  // Flags for the sequencer
  assign st.lim_small = lim < spc_pkg::LIM_W'(spc_pkg::FIRST_PRIME);
  assign st.k_eq_lim  = k == lim_ext;
  assign st.sq_gt_lim = sq > lim_ext;
  assign st.bit_set   = rdata;
  assign st.kp_le_lim = k_plus_p <= lim_ext;

  // Store ports: entries 0 and 1 start cleared, the rest as candidates
  assign mem_we = uw.mem_we;
  assign waddr  = k[spc_pkg::LIM_W-1:0];
  assign wdata  = uw.wr_init ? (k >= spc_pkg::K_W'(spc_pkg::FIRST_PRIME)) : 1'b0;
  assign raddr  = uw.rd_k ? k[spc_pkg::LIM_W-1:0] : spc_pkg::LIM_W'(p);

  assign prime_count = total;

  // Index update
  always_comb begin
    case (uw.k_op)
      spc_pkg::K_HOLD:    k_next = k;
      spc_pkg::K_ZERO:    k_next = '0;
      spc_pkg::K_INC:     k_next = k + 1'b1;
      spc_pkg::K_LOAD_SQ: k_next = sq;
      spc_pkg::K_ADD_P:   k_next = k_plus_p;
      spc_pkg::K_TWO:     k_next = spc_pkg::K_W'(spc_pkg::FIRST_PRIME);
      default:            k_next = k;
    endcase
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      lim <= limit;
    end
    k <= k_next;
    case (uw.p_op)
      spc_pkg::P_INIT: begin
        p  <= spc_pkg::P_W'(spc_pkg::FIRST_PRIME);
        sq <= spc_pkg::K_W'(spc_pkg::FIRST_PRIME * spc_pkg::FIRST_PRIME);
      end
      spc_pkg::P_INC: begin
        // (p+1)^2 = p^2 + 2p + 1
        p  <= p + 1'b1;
        sq <= sq + spc_pkg::K_W'({p, 1'b1});
      end
      default: begin
        p  <= p;
        sq <= sq;
      end
    endcase
    case (uw.tot_op)
      spc_pkg::T_CLEAR: total <= '0;
      spc_pkg::T_ACC:   total <= total + spc_pkg::CNT_W'(pend & rdata);
      default:          total <= total;
    endcase
  end

  // Read-in-flight flag for the counting pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      case (uw.pend_op)
        spc_pkg::F_SET: pend <= 1'b1;
        spc_pkg::F_CLR: pend <= 1'b0;
        default:        pend <= pend;
      endcase
    end
  end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sieve_prime_counter_top. Limits go in over in_ch
// and prime counts come back over out_ch. Both sides idle at random. A local
// sieve works out the expected count of each limit, and every count that
// comes back is checked in order.
// ----------------------------------------------------------------------------
module testbench;
  import spc_pkg::*;

  localparam int unsigned MAX_LIMIT   = DEPTH - 1;
  localparam int unsigned RANDOM_RUNS = 82;
  localparam int unsigned DRAIN_WAIT  = 16;

  typedef struct {
    logic [LIM_W-1:0] limit;
    logic [CNT_W-1:0] count;
  } pending_count_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  spc_in_if  in_ch ();
  spc_out_if out_ch ();

  sieve_prime_counter_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Local copy of the sieve store
  bit             is_candidate [0:DEPTH-1];
  pending_count_t pending_counts[$];
  bit             no_idle;
  int unsigned    mismatches;
  int unsigned    limits_sent;
  int unsigned    counts_checked;
  int unsigned    largest_limit;

  // Primes in 2..lim, by crossing out multiples in the local store
  function automatic logic [CNT_W-1:0] count_primes_upto(input logic [LIM_W-1:0] lim);
    int unsigned top;
    int unsigned base;
    int unsigned idx;
    int unsigned found;
    top   = 32'(lim);
    found = 0;
    if (top > MAX_LIMIT) begin
      top = MAX_LIMIT;
    end
    if (top < 2) begin
      return '0;
    end
    for (idx = 0; idx <= top; idx++) begin
      is_candidate[LIM_W'(idx)] = 1'b1;
    end
    is_candidate[0] = 1'b0;
    is_candidate[1] = 1'b0;
    for (base = 2; base * base <= top; base++) begin
      if (is_candidate[LIM_W'(base)]) begin
        for (idx = base * base; idx <= top; idx += base) begin
          is_candidate[LIM_W'(idx)] = 1'b0;
        end
      end
    end
    for (idx = 2; idx <= top; idx++) begin
      found += 32'(is_candidate[LIM_W'(idx)]);
    end
    return found[CNT_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    mismatches++;
  endtask

  // One limit transaction; valid is left high so a back-to-back item follows
  task automatic send_limit(input logic [LIM_W-1:0] lim);
    int unsigned gap;
    pending_count_t entry;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.limit <= lim;
    do @(posedge clk); while (!in_ch.ready);
    entry.limit = lim;
    entry.count = count_primes_upto(lim);
    pending_counts.push_back(entry);
    limits_sent++;
    if (32'(lim) > largest_limit) begin
      largest_limit = 32'(lim);
    end
  endtask

  // Result side: per transaction, hold ready low for a random stall or none
  initial begin
    int unsigned stall;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall == 0) begin
        out_ch.ready <= 1'b1;
        do @(posedge clk); while (!out_ch.valid);
      end else begin
        out_ch.ready <= 1'b0;
        do @(posedge clk); while (!out_ch.valid);
        repeat (stall - 1) @(posedge clk);
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Compare every accepted count with the oldest expectation
  always @(posedge clk) begin
    pending_count_t entry;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected prime_count %0d", out_ch.prime_count));
      end else begin
        entry = pending_counts.pop_front();
        counts_checked++;
        if (out_ch.prime_count !== entry.count) begin
          report_mismatch($sformatf("limit %0d: prime_count %0d, expected %0d",
                                    entry.limit, out_ch.prime_count, entry.count));
        end
      end
    end
  end

  // Limits below two, and the first few primes
  task automatic test_below_two();
    send_limit(16'd0);
    send_limit(16'd1);
    send_limit(16'd2);
    send_limit(16'd3);
  endtask

  // Limits at and just under a prime square, where crossing out starts or not
  task automatic test_square_edges();
    send_limit(16'd4);
    send_limit(16'd8);
    send_limit(16'd9);
    send_limit(16'd24);
    send_limit(16'd25);
    send_limit(16'd48);
    send_limit(16'd49);
    send_limit(16'd120);
    send_limit(16'd121);
    send_limit(16'd168);
    send_limit(16'd169);
  endtask

  // Full-scale limit and a few odd ones, back to back
  task automatic test_field_extremes();
    no_idle = 1'b1;
    send_limit(16'd97);
    send_limit(16'd1024);
    send_limit(16'hFFFF);
    send_limit(16'd0);
    no_idle = 1'b0;
  endtask

  // Mostly short limits, some medium, a few long; idling on and off in runs
  task automatic test_random_limits();
    int unsigned pick;
    logic [LIM_W-1:0] lim;
    for (int unsigned n = 0; n < RANDOM_RUNS; n++) begin
      if (n % 16 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        lim = LIM_W'($urandom_range(0, 3));
      end else if (pick < 85) begin
        lim = LIM_W'($urandom_range(4, 255));
      end else if (pick < 97) begin
        lim = LIM_W'($urandom_range(256, 2047));
      end else begin
        lim = LIM_W'($urandom_range(2048, 16383));
      end
      send_limit(lim);
    end
    no_idle = 1'b0;
  endtask

  // Main sequence
  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.limit    <= '0;
    no_idle        = 1'b0;
    mismatches     = 0;
    limits_sent    = 0;
    counts_checked = 0;
    largest_limit  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_below_two();
    test_square_edges();
    test_field_extremes();
    test_random_limits();
    in_ch.valid <= 1'b0;

    // Drain, then let the sequencer settle
    while (pending_counts.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d limits (largest %0d), checked %0d prime counts, %0d mismatches",
             limits_sent, largest_limit, counts_checked, mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #200_000_000;
    $display("ERROR: watchdog expired with %0d counts outstanding", pending_counts.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
